### sv/assert_macros.svh
// Assertion macros shared by the fixture table RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/crft_pkg.sv
// Shared types and constants of the channel range fixture table.
// Used by the channel interfaces and the top level; no dependencies.
package crft_pkg;

	localparam int MAX_FIXTURES_DEF = 32;

	localparam int IDENT_W  = 16;
	localparam int ADDR_W   = 10;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GET = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BOUNDS  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS = 1'b1;

	localparam logic [ADDR_W-1:0] MIN_ADDRESS_RST = 10'd1;
	localparam logic [ADDR_W-1:0] MAX_ADDRESS_RST = 10'd512;

	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [ADDR_W-1:0]  first;
		logic [ADDR_W-1:0]  last;
	} entry_t;

endpackage

### sv/crft_if.sv
// Valid/ready channel interfaces of the fixture table: request, response, configuration.
// Depends on crft_pkg for field widths.
interface crft_req_if;
	logic                         valid;
	logic                         ready;
	logic [crft_pkg::MODE_W-1:0]  mode;
	logic [crft_pkg::IDENT_W-1:0] ident;
	logic [crft_pkg::ADDR_W-1:0]  start_addr;
	logic [crft_pkg::ADDR_W-1:0]  channel_count;

	modport source (output valid, mode, ident, start_addr, channel_count, input ready);
	modport sink (input valid, mode, ident, start_addr, channel_count, output ready);
endinterface

interface crft_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [crft_pkg::STATUS_W-1:0] status;
	logic [crft_pkg::ADDR_W-1:0]   found_first;
	logic [crft_pkg::ADDR_W-1:0]   found_last;
	logic [crft_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, status, found_first, found_last, entry_count, input ready);
	modport sink (input valid, status, found_first, found_last, entry_count, output ready);
endinterface

interface crft_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [crft_pkg::CFG_IDX_W-1:0] index;
	logic [crft_pkg::ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/crft_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the fixture entries; no dependencies.
module crft_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/channel_range_fixture_table_core.sv
// Channel range fixture table: add, delete and look up identifier/range entries.
// Depends on crft_pkg, the channel interfaces, crft_ram and assert_macros.svh.
// One request at a time. The scan reads the stored entries in order through the RAM port.
// For delete, get and the unused mode a hit ends it early, and a delete then compacts the
// entries behind the hit. The response is valid next, and a new request is taken in the
// cycle after the response is accepted.
// Reset clears the entry count and restores min_address 1 and max_address 512.
`include "assert_macros.svh"

module channel_range_fixture_table_core #(
	parameter int MAX_FIXTURES = crft_pkg::MAX_FIXTURES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	crft_req_if.sink    req,
	crft_rsp_if.source  rsp,
	crft_cfg_if.sink    cfg
);

	localparam int IdxW = (MAX_FIXTURES > 1) ? $clog2(MAX_FIXTURES) : 1;
	localparam int CntW = $clog2(MAX_FIXTURES + 1);
	localparam int AW   = crft_pkg::ADDR_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MOVE = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [CntW-1:0]                 cnt_q;
	logic [CntW-1:0]                 issue_q;
	logic                            rd_vld_s1;
	logic [IdxW-1:0]                 rd_idx_s1;
	logic                            dup_q;
	logic                            ovl_q;
	logic                            hit_q;
	logic [AW-1:0]                   min_q;
	logic [AW-1:0]                   max_q;

	logic [crft_pkg::MODE_W-1:0]     mode_q;
	logic [crft_pkg::IDENT_W-1:0]    ident_q;
	logic [AW-1:0]                   start_q;
	logic [AW:0]                     last_q;
	logic                            bad_q;
	logic [IdxW-1:0]                 hit_idx_q;
	logic [AW-1:0]                   hit_first_q;
	logic [AW-1:0]                   hit_last_q;
	logic [crft_pkg::STATUS_W-1:0]   status_q;
	logic [AW-1:0]                   first_out_q;
	logic [AW-1:0]                   last_out_q;

	logic                            req_acc;
	logic [AW:0]                     req_last;
	logic                            req_bad;
	crft_pkg::entry_t                rd_entry;
	logic [$bits(crft_pkg::entry_t)-1:0] ram_rdata;
	logic                            id_match;
	logic                            ovl_match;
	logic                            scan_end;
	logic                            move_end;
	logic                            full;
	logic [crft_pkg::STATUS_W-1:0]   add_status;
	logic                            add_commit;
	logic                            move_we;
	logic                            ram_we;
	logic [IdxW-1:0]                 ram_waddr;
	crft_pkg::entry_t                ram_wdata;
	logic [CntW+5:0]                 cnt_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign req_last  = {1'b0, req.start_addr} + {1'b0, req.channel_count} - (AW+1)'(1);
	assign req_bad   = (req.channel_count == '0) || (req.start_addr < min_q) ||
	                   (req_last > {1'b0, max_q});

	assign cfg.ready = 1'b1;

	assign rd_entry  = crft_pkg::entry_t'(ram_rdata);
	assign id_match  = rd_vld_s1 && (rd_entry.ident == ident_q);
	assign ovl_match = rd_vld_s1 && ({1'b0, start_q} <= {1'b0, rd_entry.last}) &&
	                   ({1'b0, rd_entry.first} <= last_q);
	assign scan_end  = (hit_q && (mode_q != crft_pkg::MODE_ADD)) ||
	                   (!rd_vld_s1 && (issue_q == cnt_q));
	assign move_end  = !rd_vld_s1 && (issue_q == cnt_q);
	assign full      = (cnt_q == CntW'(MAX_FIXTURES));

	always_comb begin
		if (dup_q) begin
			add_status = crft_pkg::ST_DUP;
		end else if (bad_q) begin
			add_status = crft_pkg::ST_BOUNDS;
		end else if (ovl_q) begin
			add_status = crft_pkg::ST_OVERLAP;
		end else if (full) begin
			add_status = crft_pkg::ST_FULL;
		end else begin
			add_status = crft_pkg::ST_OK;
		end
	end

	assign add_commit = (state_q == ST_SCAN) && scan_end && (mode_q == crft_pkg::MODE_ADD) &&
	                    (add_status == crft_pkg::ST_OK);
	assign move_we    = (state_q == ST_MOVE) && rd_vld_s1;

	always_comb begin
		ram_we    = add_commit;
		ram_waddr = cnt_q[IdxW-1:0];
		ram_wdata = '{ident: ident_q, first: start_q, last: last_q[AW-1:0]};
		if (state_q == ST_MOVE) begin
			ram_we    = move_we;
			ram_waddr = rd_idx_s1 - IdxW'(1);
			ram_wdata = rd_entry;
		end
	end

	crft_ram #(
		.WIDTH ($bits(crft_pkg::entry_t)),
		.DEPTH (MAX_FIXTURES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (issue_q[IdxW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			dup_q     <= 1'b0;
			ovl_q     <= 1'b0;
			hit_q     <= 1'b0;
			min_q     <= crft_pkg::MIN_ADDRESS_RST;
			max_q     <= crft_pkg::MAX_ADDRESS_RST;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					crft_pkg::CFG_MIN_ADDRESS: min_q <= cfg.data;
					crft_pkg::CFG_MAX_ADDRESS: max_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						issue_q   <= '0;
						rd_vld_s1 <= 1'b0;
						dup_q     <= 1'b0;
						ovl_q     <= 1'b0;
						hit_q     <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						rd_vld_s1 <= 1'b0;
						if (add_commit) begin
							cnt_q <= cnt_q + CntW'(1);
						end
						if ((mode_q == crft_pkg::MODE_DEL) && hit_q) begin
							issue_q <= CntW'(hit_idx_q) + CntW'(1);
							state_q <= ST_MOVE;
						end else begin
							state_q <= ST_RESP;
						end
					end else begin
						dup_q     <= dup_q || id_match;
						ovl_q     <= ovl_q || ovl_match;
						hit_q     <= hit_q || id_match;
						rd_vld_s1 <= (issue_q != cnt_q);
						if (issue_q != cnt_q) begin
							issue_q <= issue_q + CntW'(1);
						end
					end
				end
				ST_MOVE: begin
					if (move_end) begin
						cnt_q   <= cnt_q - CntW'(1);
						state_q <= ST_RESP;
					end else begin
						rd_vld_s1 <= (issue_q != cnt_q);
						if (issue_q != cnt_q) begin
							issue_q <= issue_q + CntW'(1);
						end
					end
				end
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q  <= req.mode;
			ident_q <= req.ident;
			start_q <= req.start_addr;
			last_q  <= req_last;
			bad_q   <= req_bad;
		end
		rd_idx_s1 <= issue_q[IdxW-1:0];
		if ((state_q == ST_SCAN) && !scan_end && id_match) begin
			hit_idx_q   <= rd_idx_s1;
			hit_first_q <= rd_entry.first;
			hit_last_q  <= rd_entry.last;
		end
		if ((state_q == ST_SCAN) && scan_end) begin
			unique case (mode_q)
				crft_pkg::MODE_ADD: status_q <= add_status;
				crft_pkg::MODE_DEL: status_q <= hit_q ? crft_pkg::ST_OK : crft_pkg::ST_UNKNOWN;
				crft_pkg::MODE_GET: status_q <= hit_q ? crft_pkg::ST_OK : crft_pkg::ST_UNKNOWN;
				default: status_q <= crft_pkg::ST_OK;
			endcase
			if ((mode_q == crft_pkg::MODE_GET) && hit_q) begin
				first_out_q <= hit_first_q;
				last_out_q  <= hit_last_q;
			end else begin
				first_out_q <= '0;
				last_out_q  <= '0;
			end
		end
	end

	assign cnt_ext         = {6'b0, cnt_q};
	assign rsp.valid       = (state_q == ST_RESP);
	assign rsp.status      = status_q;
	assign rsp.found_first = first_out_q;
	assign rsp.found_last  = last_out_q;
	assign rsp.entry_count = cnt_ext[5:0];

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CntW'(MAX_FIXTURES))
	`ASSERT_NEXT(a_acc_scan, clk, arst_n, req_acc, state_q == ST_SCAN && !rd_vld_s1 && issue_q == '0)
	`ASSERT_IMPL(a_move_in_range, clk, arst_n, move_we, rd_idx_s1 != '0 && CntW'(rd_idx_s1) < cnt_q)
	`ASSERT_NEXT(a_add_grows, clk, arst_n, add_commit, cnt_q == $past(cnt_q) + CntW'(1))

endmodule

### bench/channel_range_fixture_table_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for channel_range_fixture_table_core: directed and random
// add/delete/get and unused-mode requests under several address windows, checked against a table model.
// Depends on crft_pkg and the channel interfaces in crft_if.sv.
module channel_range_fixture_table_core_test;

	localparam int HALF_PERIOD = 4;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 2 * crft_pkg::MAX_FIXTURES_DEF + 8;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 300;
	localparam logic [crft_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [crft_pkg::STATUS_W-1:0] status;
		logic [crft_pkg::ADDR_W-1:0]   first;
		logic [crft_pkg::ADDR_W-1:0]   last;
		logic [crft_pkg::COUNT_W-1:0]  count;
	} answer_t;

	class range_table_scoreboard;
		logic [crft_pkg::ADDR_W-1:0] lowest;
		logic [crft_pkg::ADDR_W-1:0] highest;
		crft_pkg::entry_t            entries[$];
		answer_t                     answers[$];
		int                          errors;
		int                          status_seen[8];

		function new();
			lowest = crft_pkg::MIN_ADDRESS_RST;
			highest = crft_pkg::MAX_ADDRESS_RST;
			errors = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_register(logic [crft_pkg::CFG_IDX_W-1:0] index,
			logic [crft_pkg::ADDR_W-1:0] value);
			if (index == crft_pkg::CFG_MIN_ADDRESS) lowest = value;
			else highest = value;
		endfunction

		function int find_ident(logic [crft_pkg::IDENT_W-1:0] ident);
			foreach (entries[i]) if (entries[i].ident == ident) return i;
			return -1;
		endfunction

		function logic [crft_pkg::IDENT_W-1:0] pick_ident();
			if (entries.size() == 0) return crft_pkg::IDENT_W'($urandom);
			return entries[$urandom_range(0, entries.size() - 1)].ident;
		endfunction

		function logic [crft_pkg::STATUS_W-1:0] try_add(logic [crft_pkg::IDENT_W-1:0] ident,
			logic [crft_pkg::ADDR_W-1:0] start_addr, logic [crft_pkg::ADDR_W-1:0] channel_count);
			int               last_ch;
			crft_pkg::entry_t fresh;
			if (find_ident(ident) >= 0) return crft_pkg::ST_DUP;
			if (channel_count == 0) return crft_pkg::ST_BOUNDS;
			last_ch = int'(start_addr) + int'(channel_count) - 1;
			if (start_addr < lowest || last_ch > int'(highest)) return crft_pkg::ST_BOUNDS;
			foreach (entries[i])
				if (int'(start_addr) <= int'(entries[i].last) && int'(entries[i].first) <= last_ch)
					return crft_pkg::ST_OVERLAP;
			if (entries.size() >= crft_pkg::MAX_FIXTURES_DEF) return crft_pkg::ST_FULL;
			fresh.ident = ident;
			fresh.first = start_addr;
			fresh.last = last_ch[crft_pkg::ADDR_W-1:0];
			entries.push_back(fresh);
			return crft_pkg::ST_OK;
		endfunction

		function void note_request(logic [crft_pkg::MODE_W-1:0] mode,
			logic [crft_pkg::IDENT_W-1:0] ident, logic [crft_pkg::ADDR_W-1:0] start_addr,
			logic [crft_pkg::ADDR_W-1:0] channel_count);
			answer_t want;
			int      idx;
			want = '0;
			case (mode)
				crft_pkg::MODE_ADD: want.status = try_add(ident, start_addr, channel_count);
				crft_pkg::MODE_DEL: begin
					idx = find_ident(ident);
					if (idx < 0) want.status = crft_pkg::ST_UNKNOWN;
					else entries.delete(idx);
				end
				crft_pkg::MODE_GET: begin
					idx = find_ident(ident);
					if (idx < 0) begin
						want.status = crft_pkg::ST_UNKNOWN;
					end else begin
						want.first = entries[idx].first;
						want.last = entries[idx].last;
					end
				end
				default: ;
			endcase
			want.count = crft_pkg::COUNT_W'(entries.size());
			answers.push_back(want);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(logic [crft_pkg::STATUS_W-1:0] status,
			logic [crft_pkg::ADDR_W-1:0] first, logic [crft_pkg::ADDR_W-1:0] last,
			logic [crft_pkg::COUNT_W-1:0] count);
			answer_t want;
			if (answers.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
				return;
			end
			want = answers.pop_front();
			compare_field("status", 16'(want.status), 16'(status));
			compare_field("found_first", 16'(want.first), 16'(first));
			compare_field("found_last", 16'(want.last), 16'(last));
			compare_field("entry_count", 16'(want.count), 16'(count));
			status_seen[want.status]++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	range_table_scoreboard tracker;
	bit steady = 1'b0;
	bit filling = 1'b1;
	int stall_left = 0;
	int idle_cycles = 0;
	int requests_sent = 0;

	crft_req_if req_ch();
	crft_rsp_if rsp_ch();
	crft_cfg_if cfg_ch();

	channel_range_fixture_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int pick_pause();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 99) < 25) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= pick_pause() - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			tracker.check_response(rsp_ch.status, rsp_ch.found_first, rsp_ch.found_last,
				rsp_ch.entry_count);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) === 1'b1 || (rsp_ch.valid && rsp_ch.ready) === 1'b1
			|| (cfg_ch.valid && cfg_ch.ready) === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic issue_request(input logic [crft_pkg::MODE_W-1:0] mode,
		input logic [crft_pkg::IDENT_W-1:0] ident, input logic [crft_pkg::ADDR_W-1:0] start_addr,
		input logic [crft_pkg::ADDR_W-1:0] channel_count);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.ident <= ident;
		req_ch.start_addr <= start_addr;
		req_ch.channel_count <= channel_count;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_request(mode, ident, start_addr, channel_count);
		requests_sent++;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (tracker.answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [crft_pkg::CFG_IDX_W-1:0] index,
		input logic [crft_pkg::ADDR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		tracker.set_register(index, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_requests();
		issue_request(crft_pkg::MODE_GET, 16'd0, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_DEL, 16'd0, 10'd0, 10'd0);
		issue_request(MODE_UNUSED, 16'hFFFF, 10'h3FF, 10'h3FF);
		issue_request(crft_pkg::MODE_ADD, 16'd0, 10'd1, 10'd1);
		issue_request(crft_pkg::MODE_ADD, 16'hFFFF, 10'd512, 10'd1);
		issue_request(crft_pkg::MODE_ADD, 16'd0, 10'd300, 10'd4);
		issue_request(crft_pkg::MODE_ADD, 16'd0, 10'd300, 10'd0);
		issue_request(crft_pkg::MODE_ADD, 16'd5, 10'd0, 10'd1);
		issue_request(crft_pkg::MODE_ADD, 16'd6, 10'd510, 10'd4);
		issue_request(crft_pkg::MODE_ADD, 16'd7, 10'd100, 10'd0);
		issue_request(crft_pkg::MODE_ADD, 16'd8, 10'd1023, 10'd512);
		issue_request(crft_pkg::MODE_ADD, 16'd9, 10'd1, 10'd1);
		issue_request(crft_pkg::MODE_ADD, 16'd10, 10'd2, 10'd511);
		issue_request(crft_pkg::MODE_ADD, 16'hAAAA, 10'd2, 10'd510);
		issue_request(crft_pkg::MODE_GET, 16'd0, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_GET, 16'hFFFF, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_GET, 16'hAAAA, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_GET, 16'h5555, 10'h3FF, 10'h3FF);
		issue_request(crft_pkg::MODE_DEL, 16'd0, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_GET, 16'hFFFF, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_GET, 16'hAAAA, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_DEL, 16'hAAAA, 10'd0, 10'd0);
		issue_request(crft_pkg::MODE_DEL, 16'hAAAA, 10'd0, 10'd0);
		issue_request(MODE_UNUSED, 16'h1234, 10'd5, 10'd5);
	endtask

	task automatic random_request();
		int                            roll;
		int                            kind;
		int                            add_share;
		int                            held;
		logic [crft_pkg::MODE_W-1:0]   mode;
		logic [crft_pkg::IDENT_W-1:0]  ident;
		logic [crft_pkg::ADDR_W-1:0]   start_addr;
		logic [crft_pkg::ADDR_W-1:0]   channel_count;
		held = tracker.entries.size();
		if (held >= crft_pkg::MAX_FIXTURES_DEF) filling = 1'b0;
		else if (held == 0) filling = 1'b1;
		else if ($urandom_range(0, 79) == 0) filling = !filling;
		add_share = filling ? 65 : 20;
		ident = crft_pkg::IDENT_W'($urandom);
		start_addr = crft_pkg::ADDR_W'($urandom);
		channel_count = crft_pkg::ADDR_W'($urandom_range(0, 512));
		roll = $urandom_range(0, 99);
		if (roll < add_share) begin
			mode = crft_pkg::MODE_ADD;
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				if (tracker.lowest <= tracker.highest)
					start_addr = crft_pkg::ADDR_W'($urandom_range(tracker.lowest,
						tracker.highest));
				channel_count = crft_pkg::ADDR_W'($urandom_range(1,
					($urandom_range(0, 99) < 80) ? 3 : 24));
				if (kind >= 75) ident = tracker.pick_ident();
			end else if (kind < 92) begin
				channel_count = $urandom_range(0, 1) ? 10'd0 :
					crft_pkg::ADDR_W'($urandom_range(1, 512));
			end
		end else begin
			if (roll < add_share + (filling ? 12 : 45)) mode = crft_pkg::MODE_DEL;
			else if (roll < 97) mode = crft_pkg::MODE_GET;
			else mode = MODE_UNUSED;
			if ($urandom_range(0, 99) < 85) ident = tracker.pick_ident();
		end
		issue_request(mode, ident, start_addr, channel_count);
	endtask

	initial begin
		int phase_low[PHASES];
		int phase_high[PHASES];
		phase_low = '{0, 0, 1023, 700, 0, 256};
		phase_high = '{1023, 63, 1023, 200, 0, 767};
		tracker = new();
		req_ch.valid = 1'b0;
		req_ch.mode = crft_pkg::MODE_ADD;
		req_ch.ident = '0;
		req_ch.start_addr = '0;
		req_ch.channel_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = crft_pkg::CFG_MIN_ADDRESS;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		directed_requests();
		for (int p = 0; p < PHASES; p++) begin
			settle();
			steady = (p == 1 || p == 4);
			write_register(crft_pkg::CFG_MIN_ADDRESS, crft_pkg::ADDR_W'(phase_low[p]));
			write_register(crft_pkg::CFG_MAX_ADDRESS, crft_pkg::ADDR_W'(phase_high[p]));
			repeat (PHASE_REQUESTS) random_request();
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;
		while (tracker.answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests over %0d address windows: %0d accepted, %0d duplicate,",
			requests_sent, PHASES + 1, tracker.status_seen[crft_pkg::ST_OK],
			tracker.status_seen[crft_pkg::ST_DUP]);
		$display("%0d out of bounds, %0d overlapping, %0d unknown and %0d table-full results.",
			tracker.status_seen[crft_pkg::ST_BOUNDS], tracker.status_seen[crft_pkg::ST_OVERLAP],
			tracker.status_seen[crft_pkg::ST_UNKNOWN], tracker.status_seen[crft_pkg::ST_FULL]);
		if (tracker.errors == 0 && tracker.answers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
